// File: src/olid_pkg.sv
// olid_pkg: shared sizes, codes, command structs and word conversion functions
// for the ordered list block. Depends on nothing; used by every module in src.
package olid_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;

    // field widths fixed by the interface
    localparam int VAL_W  = 32;
    localparam int POS_W  = 7;
    localparam int ELEM_W = 7;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [CMP_W-1:0]     t_cmp;

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_DELETE = 2'd1,
        FN_INSERT = 2'd2,
        FN_READ   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD_POS   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // command from the sequencer to every cell, valid for the execute cycle only
    typedef struct packed {
        logic  do_ins;
        logic  do_del;
        logic  do_rd;
        t_cmp  pos;
        t_cmp  count;
        t_word word;
    } t_cmd;

    // what the row hands back to the sequencer
    typedef struct packed {
        logic  found;
        t_word rd_word;
    } t_row_stat;

    // sign-extend or truncate the 32-bit field into a stored word
    function automatic t_word to_word(input logic [VAL_W-1:0] v);
        t_word w;
        for (int b = 0; b < WORD_BITS; b++) begin
            w[b] = v[(b < VAL_W) ? b : VAL_W - 1];
        end
        return w;
    endfunction

    // sign-extend or truncate a stored word back to the 32-bit field
    function automatic logic [VAL_W-1:0] to_field(input t_word w);
        logic [VAL_W-1:0] v;
        for (int b = 0; b < VAL_W; b++) begin
            v[b] = w[(b < WORD_BITS) ? b : WORD_BITS - 1];
        end
        return v;
    endfunction

endpackage

// File: src/ordered_list_insert_delete.sv
// ordered_list_insert_delete: top level; request sequencer, count register and
// result register around the cell row. Depends on olid_pkg and olid_cell_row.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  request | i_in_valid/o_in_ready, func/value/pos     | in
//  result  | o_out_valid/i_out_ready, status/count/rd  | out
//
// every request passes S_IDLE, where cells compare on the accept edge, and then
// S_EXEC, where the match chain settles and an insert or delete shifts one slot.
// the result register frees the row: a request is taken while a result waits
// only if that result leaves on the same edge.
// synchronous active-low reset empties the list; stored words keep no reset.
module ordered_list_insert_delete (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_value,
    input  logic [6:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_element_count,
    output logic [31:0] o_read_value
);
    import olid_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    t_func  r_func;
    t_word  r_word;
    t_cmp   r_pos;
    logic   r_out_valid, n_out_valid;
    logic [1:0]        r_status, n_status;
    logic [VAL_W-1:0]  r_rd, n_rd;

    t_cmd      cmd;
    t_row_stat stat;
    logic      accept;
    logic      full;
    t_cmp      count_ext;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_W'(DEPTH));
    assign count_ext  = CMP_W'(r_count);

    olid_cell_row u_row (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_cmp_word (to_word(i_value)),
        .i_count    (r_count),
        .o_stat     (stat)
    );

    always_comb begin
        cmd         = '0;
        cmd.word    = r_word;
        cmd.count   = count_ext;
        cmd.pos     = r_pos;
        n_state     = r_state;
        n_count     = r_count;
        n_status    = r_status;
        n_rd        = r_rd;
        n_out_valid = r_out_valid && !i_out_ready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_status    = ST_OK;
                n_rd        = '0;
                unique case (r_func)
                    FN_APPEND: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd.do_ins = 1'b1;
                            cmd.pos    = count_ext;
                            n_count    = r_count + 1'b1;
                        end
                    end
                    FN_DELETE: begin
                        if (!stat.found) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            cmd.do_del = 1'b1;
                            n_count    = r_count - 1'b1;
                        end
                    end
                    FN_INSERT: begin
                        if (r_pos > count_ext) begin
                            n_status = ST_BAD_POS;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            cmd.do_ins = 1'b1;
                            n_count    = r_count + 1'b1;
                        end
                    end
                    FN_READ: begin
                        if (r_pos >= count_ext) begin
                            n_status = ST_BAD_POS;
                        end else begin
                            cmd.do_rd = 1'b1;
                            n_rd      = to_field(stat.rd_word);
                        end
                    end
                    default: n_status = ST_OK;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // request beat and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= t_func'(i_func);
            r_word <= to_word(i_value);
            r_pos  <= CMP_W'(i_position);
        end
        r_status <= n_status;
        r_rd     <= n_rd;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_element_count = ELEM_W'(r_count);
    assign o_read_value    = r_rd;

endmodule

// File: src/olid_cell.sv
// olid_cell: one list slot; holds a word, compares it, shifts from either neighbor.
// Depends on olid_pkg.
module olid_cell (
    input  logic           i_clk,
    input  olid_pkg::t_idx i_idx,
    input  olid_pkg::t_cmd i_cmd,
    input  olid_pkg::t_word i_cmp_word,
    input  olid_pkg::t_cnt i_count,
    input  olid_pkg::t_word i_left_word,
    input  olid_pkg::t_word i_right_word,
    input  logic           i_hit_above,
    input  olid_pkg::t_word i_rd_above,
    output olid_pkg::t_word o_word,
    output logic           o_hit_below,
    output olid_pkg::t_word o_rd_below
);
    import olid_pkg::*;

    t_word r_word;
    t_word n_word;
    logic  r_match;
    t_cmp  idx_ext;
    logic  live;
    logic  rd_sel;

    assign idx_ext = CMP_W'(i_idx);
    assign live    = idx_ext < CMP_W'(i_count);

    always_comb begin
        n_word = r_word;
        if (i_cmd.do_ins) begin
            if (idx_ext == i_cmd.pos) begin
                n_word = i_cmd.word;
            end else if (idx_ext > i_cmd.pos && idx_ext <= i_cmd.count) begin
                n_word = i_left_word;
            end
        end else if (i_cmd.do_del) begin
            // no match above this slot means it sits at or above the removed one
            if (!i_hit_above && idx_ext < i_cmd.count) begin
                n_word = i_right_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_match <= live && (r_word == i_cmp_word);
    end

    assign rd_sel      = i_cmd.do_rd && (idx_ext == i_cmd.pos);
    assign o_word      = r_word;
    assign o_hit_below = i_hit_above | r_match;
    assign o_rd_below  = i_rd_above | (rd_sel ? r_word : '0);

endmodule

// File: src/olid_cell_row.sv
// olid_cell_row: chain of DEPTH cells with neighbor shift paths, a match chain
// and a read chain running toward slot zero. Depends on olid_pkg and olid_cell.
module olid_cell_row (
    input  logic                i_clk,
    input  olid_pkg::t_cmd      i_cmd,
    input  olid_pkg::t_word     i_cmp_word,
    input  olid_pkg::t_cnt      i_count,
    output olid_pkg::t_row_stat o_stat
);
    import olid_pkg::*;

    t_word words [DEPTH];
    logic  hit   [DEPTH+1];
    t_word rd    [DEPTH+1];

    assign hit[DEPTH] = 1'b0;
    assign rd[DEPTH]  = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word left_word;
        t_word right_word;

        if (g == 0) begin : g_first
            assign left_word = '0;
        end else begin : g_mid_l
            assign left_word = words[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_word = '0;
        end else begin : g_mid_r
            assign right_word = words[g+1];
        end

        olid_cell u_cell (
            .i_clk        (i_clk),
            .i_idx        (IDX_W'(g)),
            .i_cmd        (i_cmd),
            .i_cmp_word   (i_cmp_word),
            .i_count      (i_count),
            .i_left_word  (left_word),
            .i_right_word (right_word),
            .i_hit_above  (hit[g+1]),
            .i_rd_above   (rd[g+1]),
            .o_word       (words[g]),
            .o_hit_below  (hit[g]),
            .o_rd_below   (rd[g])
        );
    end

    assign o_stat.found   = hit[0];
    assign o_stat.rd_word = rd[0];

endmodule

// File: tb/tb_ordered_list_insert_delete.sv
// tb_ordered_list_insert_delete: self-checking bench for the ordered list block,
// a directed table then bursty random requests checked beat by beat.
// Depends on olid_pkg and ordered_list_insert_delete from src.
module tb_ordered_list_insert_delete;
    import olid_pkg::*;

    typedef struct packed {
        t_status     status;
        logic [6:0]  count;
        logic [31:0] rd;
    } t_result;

    typedef struct packed {
        t_func       fn;
        logic [31:0] value;
        logic [6:0]  pos;
        logic        typed;
        t_status     status;
        logic [6:0]  count;
        logic [31:0] rd;
    } t_dir_row;

    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } t_mix;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func = FN_APPEND;
    logic [31:0] i_value = '0;
    logic [6:0]  i_position = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [6:0]  o_element_count;
    logic [31:0] o_read_value;

    // mirror of the list contents
    logic [31:0] list_words [DEPTH];
    int          list_len = 0;
    int          deepest_fill = 0;

    t_result     pending_results [$];
    int          mismatch_count = 0;
    int          status_seen [4] = '{0, 0, 0, 0};
    int          results_seen = 0;

    // receiver stall pattern state
    int          phase_left = 0;
    int          ready_mode = 0;
    int          ready_tick = 0;
    int          run_left = 0;
    logic        run_hold = 1'b0;

    t_dir_row dir_rows [25] = '{
        '{FN_READ,   32'h0,        7'd0,   1'b1, ST_BAD_POS,   7'd0, 32'h0},
        '{FN_DELETE, 32'h5,        7'd0,   1'b1, ST_NOT_FOUND, 7'd0, 32'h0},
        '{FN_INSERT, 32'h7,        7'd1,   1'b1, ST_BAD_POS,   7'd0, 32'h0},
        '{FN_INSERT, 32'h7,        7'd127, 1'b1, ST_BAD_POS,   7'd0, 32'h0},
        '{FN_APPEND, 32'h7fffffff, 7'd0,   1'b1, ST_OK,        7'd1, 32'h0},
        '{FN_APPEND, 32'h80000000, 7'd127, 1'b1, ST_OK,        7'd2, 32'h0},
        '{FN_READ,   32'h0,        7'd0,   1'b1, ST_OK,        7'd2, 32'h7fffffff},
        '{FN_READ,   32'hffffffff, 7'd1,   1'b1, ST_OK,        7'd2, 32'h80000000},
        '{FN_READ,   32'h0,        7'd2,   1'b1, ST_BAD_POS,   7'd2, 32'h0},
        '{FN_READ,   32'h0,        7'd127, 1'b1, ST_BAD_POS,   7'd2, 32'h0},
        '{FN_INSERT, 32'hffffffff, 7'd0,   1'b1, ST_OK,        7'd3, 32'h0},
        '{FN_INSERT, 32'h5,        7'd3,   1'b1, ST_OK,        7'd4, 32'h0},
        '{FN_INSERT, 32'h5,        7'd2,   1'b1, ST_OK,        7'd5, 32'h0},
        '{FN_APPEND, 32'h0,        7'd0,   1'b1, ST_OK,        7'd6, 32'h0},
        // two copies of 5 held: the later one must go
        '{FN_DELETE, 32'h5,        7'd0,   1'b0, ST_OK,        7'd0, 32'h0},
        '{FN_READ,   32'h0,        7'd3,   1'b0, ST_OK,        7'd0, 32'h0},
        '{FN_READ,   32'h0,        7'd4,   1'b0, ST_OK,        7'd0, 32'h0},
        '{FN_DELETE, 32'h12345678, 7'd0,   1'b1, ST_NOT_FOUND, 7'd5, 32'h0},
        '{FN_DELETE, 32'h7fffffff, 7'd0,   1'b0, ST_OK,        7'd0, 32'h0},
        '{FN_DELETE, 32'h80000000, 7'd0,   1'b0, ST_OK,        7'd0, 32'h0},
        '{FN_APPEND, 32'h55555555, 7'd0,   1'b0, ST_OK,        7'd0, 32'h0},
        '{FN_APPEND, 32'haaaaaaaa, 7'd0,   1'b0, ST_OK,        7'd0, 32'h0},
        '{FN_INSERT, 32'h0,        7'd5,   1'b0, ST_OK,        7'd0, 32'h0},
        '{FN_READ,   32'h0,        7'd5,   1'b0, ST_OK,        7'd0, 32'h0},
        '{FN_DELETE, 32'hffffffff, 7'd0,   1'b0, ST_OK,        7'd0, 32'h0}
    };

    ordered_list_insert_delete i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_read_value    (o_read_value)
    );

    always #2 i_clk = ~i_clk;

    // applies one request to the mirrored list and returns its result
    function automatic t_result list_apply(t_func fn, logic [31:0] v, logic [6:0] p);
        t_result r;
        int      hit;
        r.status = ST_OK;
        r.rd     = '0;
        case (fn)
            FN_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = v;
                    list_len++;
                end
            end
            FN_DELETE: begin
                hit = -1;
                for (int i = 0; i < list_len; i++) begin
                    if (list_words[i] == v) hit = i;
                end
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int i = hit; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
                    list_len--;
                end
            end
            FN_INSERT: begin
                // position is checked before fullness
                if (int'(p) > list_len) begin
                    r.status = ST_BAD_POS;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > int'(p); i--) list_words[i] = list_words[i - 1];
                    list_words[p] = v;
                    list_len++;
                end
            end
            default: begin
                if (int'(p) >= list_len) r.status = ST_BAD_POS;
                else r.rd = list_words[p];
            end
        endcase
        r.count = list_len[6:0];
        if (list_len > deepest_fill) deepest_fill = list_len;
        return r;
    endfunction

    // held values often, so deletes hit; a small pool for duplicates
    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && list_len > 0) return list_words[$urandom_range(0, list_len - 1)];
        if (sel < 7) return 32'($urandom_range(0, 6)) - 32'd3;
        if (sel == 7) return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
        return $urandom();
    endfunction

    function automatic logic [6:0] pick_pos(int top);
        if ($urandom_range(0, 9) == 0 || top < 0) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, top));
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    // called right after a falling edge; returns at the falling edge after the accept
    task automatic send_item(t_func fn, logic [31:0] v, logic [6:0] p,
                             logic typed, t_result typed_res);
        t_result res;
        i_in_valid = 1'b1;
        i_func     = fn;
        i_value    = v;
        i_position = p;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        res = list_apply(fn, v, p);
        if (typed) res = typed_res;
        pending_results.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid = 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (phase_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(30, 150);
        end
        phase_left--;
        ready_tick++;
        case (ready_mode)
            0: i_out_ready = 1'b1;
            1: i_out_ready = ($urandom_range(0, 3) != 0);
            2: i_out_ready = (ready_tick % 5) != 2;
            default: begin
                if (run_left == 0) begin
                    run_hold = ~run_hold;
                    run_left = run_hold ? $urandom_range(1, 10) : $urandom_range(1, 15);
                end
                run_left--;
                i_out_ready = run_hold;
            end
        endcase
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            status_seen[o_status]++;
            if (pending_results.size() == 0) begin
                note_mismatch("result beat with nothing pending", 32'h0, o_read_value);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_element_count !== want.count)
                    note_mismatch("element_count", 32'(want.count), 32'(o_element_count));
                if (o_read_value !== want.rd)
                    note_mismatch("read_value", want.rd, o_read_value);
            end
        end
    end

    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    initial begin
        t_result  typed_res;
        t_func    fn;
        t_mix     mix;
        logic [31:0] v;
        logic [6:0]  p;
        int       sent;
        int       burst;
        int       gap;
        int       mix_left;
        int       roll;
        int       wait_cycles;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            typed_res.status = dir_rows[k].status;
            typed_res.count  = dir_rows[k].count;
            typed_res.rd     = dir_rows[k].rd;
            send_item(dir_rows[k].fn, dir_rows[k].value, dir_rows[k].pos,
                      dir_rows[k].typed, typed_res);
        end
        drain_results();

        sent     = 0;
        mix_left = 0;
        mix      = MIX_GROW;
        typed_res = '0;
        while (sent < 900) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < 900; j++) begin
                if (mix_left == 0) begin
                    mix      = t_mix'($urandom_range(0, 2));
                    mix_left = $urandom_range(20, 90);
                end
                mix_left--;
                roll = $urandom_range(0, 99);
                case (mix)
                    MIX_GROW:   fn = (roll < 45) ? FN_APPEND : (roll < 80) ? FN_INSERT :
                                     (roll < 90) ? FN_READ : FN_DELETE;
                    MIX_SHRINK: fn = (roll < 60) ? FN_DELETE : (roll < 80) ? FN_READ :
                                     (roll < 90) ? FN_APPEND : FN_INSERT;
                    default:    fn = t_func'(roll % 4);
                endcase
                v = pick_value();
                p = pick_pos((fn == FN_INSERT) ? list_len : list_len - 1);
                send_item(fn, v, p, 1'b0, typed_res);
                sent++;
            end
            if ($urandom_range(0, 7) == 0) begin
                drain_results();
            end else begin
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    i_in_valid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
        i_in_valid = 1'b0;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 5000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            mismatch_count += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("%0d requests answered: %0d ok, %0d not found, %0d bad position, %0d full",
                 results_seen, status_seen[ST_OK], status_seen[ST_NOT_FOUND],
                 status_seen[ST_BAD_POS], status_seen[ST_FULL]);
        $display("list filled to %0d of %0d entries, %0d mismatches", deepest_fill, DEPTH,
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
